// ----- hdl/tkk_pkg.sv -----
// ----------------------------------------------------------------------------
// tkk_pkg: shared types and constants for the top-k largest keeper
// Holds the heap size, the derived widths and the sequencer's request type.
// ----------------------------------------------------------------------------
package tkk_pkg;

  // Heap capacity in entries
  localparam int CAPACITY = 1024;

  // Widths derived from the capacity
  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CHILD_W = ADDR_W + 1;

  // Fixed field widths
  localparam int DATA_W = 64;
  localparam int KEEP_W = 11;

  // keep_count after reset
  localparam logic [KEEP_W-1:0] KEEP_RESET = 11'd1024;

  // Input action codes
  localparam logic ACT_OFFER  = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  // Offer request from the top level to the heap sequencer
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] value;
  } walk_req_t;

endpackage

// ----- hdl/tkk_heap_ram.sv -----
// ----------------------------------------------------------------------------
// tkk_heap_ram: heap storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tkk_heap_ram (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [tkk_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [tkk_pkg::DATA_W-1:0]  wr_data,
  input  logic [tkk_pkg::ADDR_W-1:0]  rd_addr,
  output logic [tkk_pkg::DATA_W-1:0]  rd_data
);

  logic [tkk_pkg::DATA_W-1:0] mem [tkk_pkg::CAPACITY];
  logic [tkk_pkg::DATA_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/tkk_walker.sv -----
// ----------------------------------------------------------------------------
// tkk_walker: heap sequencer
// Inserts or replaces the minimum and walks the heap one level at a time,
// using a single shared 64-bit less-than compare. Also keeps the running sum.
// ----------------------------------------------------------------------------
module tkk_walker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tkk_pkg::walk_req_t          req,
  input  logic [tkk_pkg::CNT_W-1:0]   eff_k,
  output logic                        busy,
  output logic [tkk_pkg::DATA_W-1:0]  total
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_UP_CHK = 8'b0000_0010,
    ST_UP_CMP = 8'b0000_0100,
    ST_RT_CMP = 8'b0000_1000,
    ST_RT_ADD = 8'b0001_0000,
    ST_DN_L   = 8'b0010_0000,
    ST_DN_R   = 8'b0100_0000,
    ST_DN_C   = 8'b1000_0000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [tkk_pkg::ADDR_W-1:0]   pos_r, pos_nxt;
  logic [tkk_pkg::DATA_W-1:0]   val_r, val_nxt;
  logic [tkk_pkg::DATA_W-1:0]   cand_r, cand_nxt;
  logic                         lsel_r, lsel_nxt;
  logic [tkk_pkg::CNT_W-1:0]    held_r, held_nxt;
  logic [tkk_pkg::DATA_W-1:0]   total_r, total_nxt;

  logic                         wr_en;
  logic [tkk_pkg::ADDR_W-1:0]   wr_addr;
  logic [tkk_pkg::DATA_W-1:0]   wr_data;
  logic [tkk_pkg::ADDR_W-1:0]   rd_addr;
  logic [tkk_pkg::DATA_W-1:0]   rd_data;

  logic [tkk_pkg::DATA_W-1:0]   cmp_a, cmp_b;
  logic                         lt;
  logic [tkk_pkg::ADDR_W-1:0]   parent;
  logic [tkk_pkg::CHILD_W-1:0]  lc, rc, held_x;

  tkk_heap_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Tree navigation
  assign parent = (pos_r - tkk_pkg::ADDR_W'(1)) >> 1;
  assign lc     = {pos_r, 1'b1};
  assign rc     = lc + tkk_pkg::CHILD_W'(1);
  assign held_x = tkk_pkg::CHILD_W'(held_r);

  // Shared compare unit
  assign lt = cmp_a < cmp_b;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    cand_nxt  = cand_r;
    lsel_nxt  = lsel_r;
    held_nxt  = held_r;
    total_nxt = total_r;
    wr_en     = 1'b0;
    wr_addr   = pos_r;
    wr_data   = val_r;
    rd_addr   = '0;
    cmp_a     = rd_data;
    cmp_b     = val_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          val_nxt = req.value;
          if (held_r < eff_k) begin
            // room left: append and sift up
            pos_nxt   = held_r[tkk_pkg::ADDR_W-1:0];
            held_nxt  = held_r + tkk_pkg::CNT_W'(1);
            total_nxt = total_r + req.value;
            state_nxt = ST_UP_CHK;
          end else begin
            // full: fetch the minimum
            rd_addr   = '0;
            state_nxt = ST_RT_CMP;
          end
        end
      end
      ST_UP_CHK: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          rd_addr   = parent;
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        // parent larger than the new value: move it down
        cmp_a = val_r;
        cmp_b = rd_data;
        wr_en = 1'b1;
        if (lt) begin
          wr_data   = rd_data;
          pos_nxt   = parent;
          state_nxt = ST_UP_CHK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RT_CMP: begin
        // replace the minimum only if the offer is strictly larger
        if (lt) begin
          total_nxt = total_r - rd_data;
          pos_nxt   = '0;
          state_nxt = ST_RT_ADD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RT_ADD: begin
        total_nxt = total_r + val_r;
        state_nxt = ST_DN_L;
      end
      ST_DN_L: begin
        if (lc < held_x) begin
          rd_addr   = lc[tkk_pkg::ADDR_W-1:0];
          state_nxt = ST_DN_R;
        end else begin
          wr_en     = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DN_R: begin
        // left child against the moving value
        lsel_nxt = lt;
        cand_nxt = lt ? rd_data : val_r;
        if (rc < held_x) begin
          rd_addr   = rc[tkk_pkg::ADDR_W-1:0];
          state_nxt = ST_DN_C;
        end else begin
          wr_en = 1'b1;
          if (lt) begin
            wr_data   = rd_data;
            pos_nxt   = lc[tkk_pkg::ADDR_W-1:0];
            state_nxt = ST_DN_L;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DN_C: begin
        // right child against the smaller of value and left child
        cmp_b = cand_r;
        wr_en = 1'b1;
        if (lt) begin
          wr_data   = rd_data;
          pos_nxt   = rc[tkk_pkg::ADDR_W-1:0];
          state_nxt = ST_DN_L;
        end else if (lsel_r) begin
          wr_data   = cand_r;
          pos_nxt   = lc[tkk_pkg::ADDR_W-1:0];
          state_nxt = ST_DN_L;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      held_r  <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      total_r <= total_nxt;
    end
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    val_r  <= val_nxt;
    cand_r <= cand_nxt;
    lsel_r <= lsel_nxt;
  end

  assign busy  = (state_r != ST_IDLE);
  assign total = total_r;

endmodule

// ----- hdl/top_k_largest_keeper_core.sv -----
// ----------------------------------------------------------------------------
// top_k_largest_keeper_core: keeps the k largest 64-bit values offered
// Min-heap of up to 1024 entries with a running sum and a report output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): in_action selects an offer of
//   in_offered_value or a report request. Output channel (out_valid /
//   out_stall) returns out_kept_sum, one result per report, none per offer.
//   cfg_valid / cfg_ready write keep_count; write it only while idle.
// Operation:
//   A report loads the output register at the edge that accepts it. An
//   offer while the heap is filling appends the value and walks it up
//   towards the root. An offer against a full heap is dropped unless it is
//   strictly larger than the minimum, which it then replaces before walking
//   down. The walk is set by the heap memory, one registered read and one
//   write per cycle, and the shared compare unit. The input is stalled
//   until the walk is done.
// Reset:
//   Heap emptied (count and sum cleared), keep_count back to 1024.
// Stall:
//   A waiting result sits in the output register; while it is held off,
//   the input is stalled for every request.
// ----------------------------------------------------------------------------
module top_k_largest_keeper_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [tkk_pkg::DATA_W-1:0]  in_offered_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tkk_pkg::DATA_W-1:0]  out_kept_sum,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tkk_pkg::KEEP_W-1:0]  cfg_keep_count
);

  logic [tkk_pkg::KEEP_W-1:0]  keep_count_r;
  logic [tkk_pkg::CNT_W-1:0]   eff_k;
  logic                        out_valid_r;
  logic [tkk_pkg::DATA_W-1:0]  out_kept_sum_r;
  logic                        busy;
  logic [tkk_pkg::DATA_W-1:0]  total;
  logic                        in_accept;
  tkk_pkg::walk_req_t          req;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= tkk_pkg::KEEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      keep_count_r <= cfg_keep_count;
    end
  end

  // Effective keep count: zero means one, clamp to capacity
  always_comb begin
    if (keep_count_r == '0) begin
      eff_k = tkk_pkg::CNT_W'(1);
    end else if (int'(keep_count_r) > tkk_pkg::CAPACITY) begin
      eff_k = tkk_pkg::CNT_W'(tkk_pkg::CAPACITY);
    end else begin
      eff_k = tkk_pkg::CNT_W'(keep_count_r);
    end
  end

  // Input handshake
  assign in_stall  = busy || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign req.start = in_accept && (in_action == tkk_pkg::ACT_OFFER);
  assign req.value = in_offered_value;

  tkk_walker u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .eff_k (eff_k),
    .busy  (busy),
    .total (total)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && (in_action == tkk_pkg::ACT_REPORT)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_action == tkk_pkg::ACT_REPORT)) begin
      out_kept_sum_r <= total;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kept_sum = out_kept_sum_r;

endmodule

// ----- tb/top_k_largest_keeper_core_test.sv -----
// ----------------------------------------------------------------------------
// top_k_largest_keeper_core_test: self-checking bench for the top-k keeper
// Drives offer and report requests under several keep counts and idling
// patterns. A sorted copy of the kept values predicts every reported sum.
// ----------------------------------------------------------------------------
module top_k_largest_keeper_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam logic [tkk_pkg::DATA_W-1:0] VALUE_MAX = {tkk_pkg::DATA_W{1'b1}};

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_action;
  logic [tkk_pkg::DATA_W-1:0] in_offered_value;
  logic                       out_valid;
  logic                       out_stall;
  logic [tkk_pkg::DATA_W-1:0] out_kept_sum;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [tkk_pkg::KEEP_W-1:0] cfg_keep_count;

  // Predicted state: kept values in ascending order, their sum, keep count
  logic [tkk_pkg::DATA_W-1:0] kept_values[$];
  logic [tkk_pkg::DATA_W-1:0] kept_total;
  int unsigned                keep_setting;
  logic [tkk_pkg::DATA_W-1:0] expected_sums[$];

  // Idling controls
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned hold_off_left;

  // Bookkeeping
  int unsigned error_count;
  int unsigned offers_sent;
  int unsigned reports_sent;
  int unsigned sums_checked;
  int unsigned most_held;
  int unsigned cycle_count;

  top_k_largest_keeper_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_offered_value (in_offered_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kept_sum     (out_kept_sum),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_keep_count   (cfg_keep_count)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run limit of %0d cycles reached", $time, LIMIT_CYCLES);
    $display("FAIL");
    $finish;
  end

  // Receiver stall: a long hold-off takes priority over random stalling
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        out_stall <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
      end
    end
  end

  // Result check against the oldest predicted sum
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_kept_sum);
        error_count++;
      end else begin
        if (out_kept_sum !== expected_sums[0]) begin
          $display("%0t: kept_sum mismatch, expected %h, actual %h",
                   $time, expected_sums[0], out_kept_sum);
          error_count++;
        end
        void'(expected_sums.pop_front());
        sums_checked++;
      end
    end
  end

  // Effective keep count: zero acts as one, saturates at capacity
  function automatic int unsigned keep_limit();
    int unsigned k;
    k = keep_setting;
    if (k == 0) k = 1;
    if (k > tkk_pkg::CAPACITY) k = tkk_pkg::CAPACITY;
    return k;
  endfunction

  // Insert into the ascending list of kept values
  task automatic insert_kept(input logic [tkk_pkg::DATA_W-1:0] val);
    int i;
    i = 0;
    while (i < kept_values.size() && kept_values[i] < val) i++;
    kept_values.insert(i, val);
  endtask

  // Update the kept set for one accepted request
  task automatic apply_request(input logic act, input logic [tkk_pkg::DATA_W-1:0] val);
    if (act == tkk_pkg::ACT_REPORT) begin
      expected_sums.insert(expected_sums.size(), kept_total);
      reports_sent++;
    end else begin
      offers_sent++;
      if (kept_values.size() < keep_limit()) begin
        insert_kept(val);
        kept_total = kept_total + val;
      end else if (kept_values.size() > 0 && val > kept_values[0]) begin
        // replace the minimum; held count stays as it is
        kept_total = kept_total - kept_values[0] + val;
        void'(kept_values.pop_front());
        insert_kept(val);
      end
      if (kept_values.size() > most_held) most_held = kept_values.size();
    end
  endtask

  // Send one request, with random idle cycles ahead of it
  task automatic send_request(input logic act, input logic [tkk_pkg::DATA_W-1:0] val);
    while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_offered_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_request(act, val);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_sums.size() != 0);
  endtask

  // Write keep_count once the block has gone idle
  task automatic write_keep_count(input int unsigned k);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_keep_count <= k[tkk_pkg::KEEP_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    keep_setting = k;
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // Offered value: mix of wide random, small, near-max and ties with the minimum
  function automatic logic [tkk_pkg::DATA_W-1:0] pick_value();
    logic [tkk_pkg::DATA_W-1:0] v;
    case ($urandom_range(6, 0))
      0: v = tkk_pkg::DATA_W'($urandom_range(1000, 0));
      1: v = VALUE_MAX - tkk_pkg::DATA_W'($urandom_range(1000, 0));
      2: v = (kept_values.size() > 0) ? kept_values[0] : {$urandom, $urandom};
      3: v = (kept_values.size() > 0) ? kept_values[0] + 64'd1 : {$urandom, $urandom};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic send_random(input int unsigned count, input int unsigned report_pct);
    logic act;
    for (int unsigned n = 0; n < count; n++) begin
      act = ($urandom_range(99, 0) < report_pct) ? tkk_pkg::ACT_REPORT : tkk_pkg::ACT_OFFER;
      send_request(act, pick_value());
    end
  endtask

  // Report on an empty heap; the offered value is ignored
  task automatic test_report_after_reset();
    send_request(tkk_pkg::ACT_REPORT, VALUE_MAX);
  endtask

  // Keep one: insert, tie dropped, larger replaces, smaller dropped
  task automatic test_keep_one();
    write_keep_count(1);
    send_request(tkk_pkg::ACT_OFFER, '0);
    send_request(tkk_pkg::ACT_OFFER, '0);
    send_request(tkk_pkg::ACT_OFFER, 64'd5);
    send_request(tkk_pkg::ACT_OFFER, 64'd3);
    send_request(tkk_pkg::ACT_REPORT, '0);
    send_request(tkk_pkg::ACT_OFFER, VALUE_MAX);
    send_request(tkk_pkg::ACT_REPORT, 64'd1);
  endtask

  // Keep three: sum wraps, a new minimum sifts to the root, a tie is kept
  task automatic test_small_heap_fill();
    write_keep_count(3);
    send_request(tkk_pkg::ACT_OFFER, VALUE_MAX);
    send_request(tkk_pkg::ACT_OFFER, 64'd1);
    send_request(tkk_pkg::ACT_REPORT, '0);
    send_request(tkk_pkg::ACT_OFFER, 64'd1);
    send_request(tkk_pkg::ACT_OFFER, 64'd2);
    send_request(tkk_pkg::ACT_REPORT, '0);
  endtask

  // Keep count lowered below the held count: no eviction, replace path only
  task automatic test_lowered_keep_count();
    write_keep_count(2);
    send_request(tkk_pkg::ACT_OFFER, 64'd7);
    send_request(tkk_pkg::ACT_OFFER, '0);
    send_request(tkk_pkg::ACT_OFFER, 64'h8000_0000_0000_0000);
    send_request(tkk_pkg::ACT_REPORT, '0);
  endtask

  // Random traffic over growing keep counts up to capacity
  task automatic test_mixed_traffic();
    set_idling(0, 0);
    write_keep_count(8);
    send_random(80, 20);
    set_idling(49, 0);
    write_keep_count(64);
    send_random(80, 20);
    set_idling(0, 49);
    write_keep_count(tkk_pkg::CAPACITY);
    send_random(550, 5);
    set_idling(14, 14);
    send_random(450, 5);
  endtask

  // Receiver holds off while requests keep coming, then the sender drains
  task automatic test_backpressure_fill();
    set_idling(0, 0);
    hold_off_left = 600;
    send_random(40, 40);
    wait_results_drained();
    send_random(30, 40);
  endtask

  // Full heap with a small keep count, then the smallest keep count
  task automatic test_full_heap_lowered();
    set_idling(14, 14);
    write_keep_count(5);
    send_random(60, 20);
    set_idling(0, 0);
    write_keep_count(1);
    send_random(40, 20);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_action        = tkk_pkg::ACT_OFFER;
    in_offered_value = '0;
    cfg_valid        = 1'b0;
    cfg_keep_count   = tkk_pkg::KEEP_RESET;
    kept_total       = '0;
    keep_setting     = int'(tkk_pkg::KEEP_RESET);
    hold_off_left    = 0;
    error_count      = 0;
    offers_sent      = 0;
    reports_sent     = 0;
    sums_checked     = 0;
    most_held        = 0;
    set_idling(0, 0);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_report_after_reset();
    test_keep_one();
    test_small_heap_fill();
    test_lowered_keep_count();
    test_mixed_traffic();
    test_backpressure_fill();
    test_full_heap_lowered();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d offers and %0d reports, %0d sums checked, %0d errors",
             offers_sent, reports_sent, sums_checked, error_count);
    $display("Keep counts 1 to %0d, up to %0d values held, with stalls and idle gaps",
             tkk_pkg::CAPACITY, most_held);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- top_k_largest_keeper_core.f -----
hdl/tkk_pkg.sv
hdl/tkk_heap_ram.sv
hdl/tkk_walker.sv
hdl/top_k_largest_keeper_core.sv
tb/top_k_largest_keeper_core_test.sv
